// ----- design/mav_pkg.sv -----
// Shared types and constants for the moving average filter.
`default_nettype none

package mav_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 7;
    localparam int WINDOW_BITS = 7;
    localparam int MAX_WINDOW  = 64;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                          operation;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic [COUNT_BITS-1:0]         held_count;
    } out_item_t;

endpackage

`default_nettype wire

// ----- design/mav_ring.sv -----
// Sample history memory with one write port and one registered read port.
`default_nettype none

module mav_ring #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/mav_divider.sv -----
// Serial restoring divider: signed dividend by unsigned divisor, one quotient bit per cycle.
`default_nettype none

module mav_divider #(
    parameter int DIVIDEND_BITS = 22,
    parameter int DIVISOR_BITS  = 7
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic signed [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]         divisor,
    output logic                                 done,
    output logic [DIVIDEND_BITS-1:0]             quotient
);

    localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic                     neg_reg, neg_next;
    logic [DIVIDEND_BITS-1:0] mag_reg, mag_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0]  div_reg, div_next;

    logic [DIVISOR_BITS:0]    shifted;
    logic [DIVISOR_BITS+1:0]  trial;

    assign shifted = {rem_reg, mag_reg[DIVIDEND_BITS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_BITS'(DIVIDEND_BITS);
            neg_next  = dividend[DIVIDEND_BITS-1];
            mag_next  = dividend[DIVIDEND_BITS-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // A clear borrow bit means the trial subtraction fits.
            if (!trial[DIVISOR_BITS+1])
            begin
                rem_next = trial[DIVISOR_BITS-1:0];
                mag_next = {mag_reg[DIVIDEND_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVISOR_BITS-1:0];
                mag_next = {mag_reg[DIVIDEND_BITS-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~mag_reg + 1'b1) : mag_reg;

endmodule

`default_nettype wire

// ----- design/moving_average_filter.sv -----
// Top level of the moving average filter: sequencer, running sum and output register.
// Add request: check, drop the oldest sample if the window is full (at most one), store,
// then divide the running sum serially, one quotient bit per running-sum bit. A next request
// can be taken once the result is offered. Clear request: zero goes straight out. A window
// write trims the oldest samples. An untaken result holds the sequencer until taken.
// Reset (asynchronous, active low) empties the window and sets the window length to one.
`default_nettype none

module moving_average_filter (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mav_pkg::WINDOW_BITS-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire mav_pkg::in_item_t                in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output mav_pkg::out_item_t                    out_data
);

    // The history memory is not cleared at reset, since only written entries are ever read.
    localparam int MAX_WINDOW = mav_pkg::MAX_WINDOW;
    localparam int SB       = mav_pkg::SAMPLE_BITS;
    localparam int PTR_BITS = $clog2(MAX_WINDOW);
    localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS = SB + PTR_BITS;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DROP   = 3'd2;
    localparam logic [2:0] ST_STORE  = 3'd3;
    localparam logic [2:0] ST_DSTART = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_PUT    = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [PTR_BITS-1:0]     ptr_reg, ptr_next;
    logic [CNT_BITS-1:0]     fill_reg, fill_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic [CNT_BITS-1:0]     window_reg, window_next;
    logic                    add_mode_reg, add_mode_next;
    logic                    clear_reg, clear_next;
    logic [SB-1:0]           sample_reg, sample_next;
    logic                    out_valid_reg, out_valid_next;
    mav_pkg::out_item_t      out_reg, out_next;

    logic                    need_drop;
    logic                    rd_en;
    logic                    wr_en;
    logic [SB-1:0]           rd_data;
    logic [CNT_BITS:0]       slot_wide;
    logic [PTR_BITS-1:0]     wr_addr;
    logic [PTR_BITS-1:0]     ptr_inc;
    logic [CNT_BITS-1:0]     window_clamped;
    logic signed [SUM_BITS-1:0] operand;
    logic signed [SUM_BITS-1:0] sum_result;
    logic                    div_start;
    logic                    div_done;
    logic [SUM_BITS-1:0]     quotient;
    logic                    out_free;

    // Requests wait while a window write is offered, so the two never collide.
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign out_free  = !out_valid_reg || out_ready;

    // A written window of zero becomes one; anything above the store depth saturates.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            window_clamped = CNT_BITS'(1);
        end
        else if (int'(cfg_data) > MAX_WINDOW)
        begin
            window_clamped = CNT_BITS'(MAX_WINDOW);
        end
        else
        begin
            window_clamped = CNT_BITS'(cfg_data);
        end
    end

    // An add request makes room for its sample; a window write only trims surplus.
    assign need_drop = add_mode_reg ? ((fill_reg >= window_reg) && (fill_reg != '0))
                                    : (fill_reg > window_reg);

    assign ptr_inc = (ptr_reg == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : ptr_reg + 1'b1;

    // The new sample goes right after the newest one held, wrapping around the ring.
    always_comb
    begin
        slot_wide = (CNT_BITS+1)'(ptr_reg) + (CNT_BITS+1)'(fill_reg);
        if (slot_wide >= (CNT_BITS+1)'(MAX_WINDOW))
        begin
            slot_wide = slot_wide - (CNT_BITS+1)'(MAX_WINDOW);
        end
    end
    assign wr_addr = slot_wide[PTR_BITS-1:0];

    // One adder serves both the oldest sample leaving and the new sample entering.
    assign operand    = (state_reg == ST_DROP)
                        ? {{PTR_BITS{rd_data[SB-1]}}, rd_data}
                        : {{PTR_BITS{sample_reg[SB-1]}}, sample_reg};
    assign sum_result = (state_reg == ST_DROP) ? (sum_reg - operand) : (sum_reg + operand);

    assign rd_en     = (state_reg == ST_CHECK) && need_drop;
    assign wr_en     = (state_reg == ST_STORE);
    assign div_start = (state_reg == ST_DSTART);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        window_next    = window_reg;
        add_mode_next  = add_mode_reg;
        clear_next     = clear_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    window_next   = window_clamped;
                    add_mode_next = 1'b0;
                    state_next    = ST_CHECK;
                end
                else if (in_valid)
                begin
                    sample_next = in_data.sample;
                    if (in_data.operation == mav_pkg::OP_CLEAR)
                    begin
                        ptr_next   = '0;
                        fill_next  = '0;
                        sum_next   = '0;
                        clear_next = 1'b1;
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        clear_next    = 1'b0;
                        add_mode_next = 1'b1;
                        state_next    = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (need_drop)
                begin
                    state_next = ST_DROP;
                end
                else if (add_mode_reg)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DROP:
            begin
                sum_next   = sum_result;
                ptr_next   = ptr_inc;
                fill_next  = fill_reg - 1'b1;
                state_next = ST_CHECK;
            end
            ST_STORE:
            begin
                sum_next   = sum_result;
                fill_next  = fill_reg + 1'b1;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.average    = clear_reg ? '0 : quotient[SB-1:0];
                    out_next.held_count = mav_pkg::COUNT_BITS'(fill_reg);
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            window_reg    <= CNT_BITS'(1);
            add_mode_reg  <= 1'b0;
            clear_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            window_reg    <= window_next;
            add_mode_reg  <= add_mode_next;
            clear_reg     <= clear_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        out_reg    <= out_next;
    end

    mav_ring #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SB)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sample_reg),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    mav_divider #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (CNT_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
